FILE: design/permutation_unrank_assert.svh
// Assertion helpers used by the checker file.
`ifndef PERMUTATION_UNRANK_ASSERT_SVH
`define PERMUTATION_UNRANK_ASSERT_SVH

// Clocked assertion, switched off while the reset is asserted.
`define PU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define PU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/punrank_pkg.sv
package punrank_pkg;

  localparam int unsigned MaxLen = 12;
  localparam int unsigned LenW   = 4;
  localparam int unsigned IdxW   = 29;
  localparam int unsigned ElemW  = 4;
  localparam int unsigned BitW   = 2;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [LenW-1:0] len;
    logic            err;
  } cmd_t;

  // k! for k = 0 .. 12
  function automatic logic [IdxW-1:0] fact(input logic [LenW-1:0] k);
    logic [IdxW-1:0] f;
    unique case (k)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = 29'd479001600;
    endcase
    return f;
  endfunction

  // Quotient bits needed for a digit that never exceeds k.
  function automatic logic [2:0] qbits(input logic [LenW-1:0] k);
    logic [2:0] b;
    priority if (k >= 4'd8) b = 3'd4;
    else if (k >= 4'd4)     b = 3'd3;
    else if (k >= 4'd2)     b = 3'd2;
    else if (k >= 4'd1)     b = 3'd1;
    else                    b = 3'd0;
    return b;
  endfunction

endpackage

FILE: design/punrank_front.sv
module punrank_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [punrank_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [punrank_pkg::IdxW-1:0] in_index_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output punrank_pkg::cmd_t           push_cmd_o
);
  import punrank_pkg::*;

  logic [LenW-1:0] len_q;
  logic [LenW-1:0] eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(MaxLen);
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // clamp the length into 1 .. MaxLen
  always_comb begin
    priority if (len_q == '0)           eff_len = LenW'(1);
    else if (len_q > LenW'(MaxLen))     eff_len = LenW'(MaxLen);
    else                                eff_len = len_q;
  end

  assign in_ready_o         = push_ready_i;
  assign push_valid_o       = in_valid_i;
  assign push_cmd_o.index   = in_index_i;
  assign push_cmd_o.len     = eff_len;
  assign push_cmd_o.err     = (in_index_i >= fact(eff_len));

endmodule

FILE: design/punrank_fifo.sv
module punrank_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  punrank_pkg::cmd_t push_cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output punrank_pkg::cmd_t pop_cmd_o
);
  import punrank_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

FILE: design/punrank_back.sv
module punrank_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  punrank_pkg::cmd_t            pop_cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [punrank_pkg::ElemW-1:0] out_elem_o,
  output logic                         out_last_o,
  output logic                         out_err_o
);
  import punrank_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_PICK = 3'b100
  } bk_state_e;

  bk_state_e        state_q, state_d;
  logic [IdxW-1:0]  rem_q, rem_d;
  logic [LenW-1:0]  k_q, k_d;
  logic [ElemW-1:0] q_q, q_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic             err_q, err_d;
  logic [ElemW-1:0] list_q [MaxLen];
  logic [ElemW-1:0] list_d [MaxLen];

  logic             ovalid_q, ovalid_d;
  logic [ElemW-1:0] oelem_q, oelem_d;
  logic             olast_q, olast_d;
  logic             oerr_q, oerr_d;

  logic             slot_free;
  logic [31:0]      div_sh;
  logic [ElemW-1:0] pick;
  logic [2:0]       nb_load, nb_next;
  logic [LenW-1:0]  k_load, k_next;

  assign slot_free   = !ovalid_q || out_ready_i;
  assign pop_ready_o = (state_q == BK_IDLE);
  assign div_sh      = {3'b000, fact(k_q)} << bit_q;
  assign pick        = (q_q < ElemW'(MaxLen)) ? list_q[q_q] : list_q[MaxLen-1];
  assign k_load      = pop_cmd_i.len - LenW'(1);
  assign k_next      = k_q - LenW'(1);
  assign nb_load     = qbits(k_load);
  assign nb_next     = qbits(k_next);

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    k_d      = k_q;
    q_d      = q_q;
    bit_d    = bit_q;
    err_d    = err_q;
    list_d   = list_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oelem_d  = oelem_q;
    olast_d  = olast_q;
    oerr_d   = oerr_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) begin
          rem_d = pop_cmd_i.index;
          k_d   = k_load;
          q_d   = '0;
          err_d = pop_cmd_i.err;
          for (int i = 0; i < MaxLen; i++) begin
            list_d[i] = ElemW'(i);
          end
          if (pop_cmd_i.err || nb_load == 3'd0) begin
            state_d = BK_PICK;
          end else begin
            bit_d   = BitW'(nb_load - 3'd1);
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        // one restoring step of rem / k!
        if ({3'b000, rem_q} >= div_sh) begin
          rem_d        = IdxW'({3'b000, rem_q} - div_sh);
          q_d[bit_q]   = 1'b1;
        end
        if (bit_q == '0) begin
          state_d = BK_PICK;
        end else begin
          bit_d = bit_q - BitW'(1);
        end
      end
      BK_PICK: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          oerr_d   = err_q;
          oelem_d  = err_q ? '0 : pick;
          olast_d  = err_q || (k_q == '0);
          // drop the picked element from the list of unused ones
          for (int i = 0; i < MaxLen - 1; i++) begin
            if (ElemW'(i) >= q_q) list_d[i] = list_q[i+1];
          end
          if (err_q || k_q == '0) begin
            state_d = BK_IDLE;
          end else begin
            k_d = k_next;
            q_d = '0;
            if (nb_next == 3'd0) begin
              state_d = BK_PICK;
            end else begin
              bit_d   = BitW'(nb_next - 3'd1);
              state_d = BK_DIV;
            end
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    k_q     <= k_d;
    q_q     <= q_d;
    bit_q   <= bit_d;
    err_q   <= err_d;
    list_q  <= list_d;
    oelem_q <= oelem_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_elem_o  = oelem_q;
  assign out_last_o  = olast_q;
  assign out_err_o   = oerr_q;

endmodule

FILE: design/permutation_unrank.sv
// Permutation unranking by factorial-base (Lehmer code) decoding.
// Slave stream: s_axis_tdata[28:0] carries a rank; the permutation of
// 0 .. n-1 with that rank in lexicographic order comes out on the master
// stream, one element per item, the final one marked by tlast.
// The length n is written through cfg_we_i / cfg_wdata_i (reset value 12;
// 0 counts as 1, values above 12 count as 12). Write it only while idle.
// A rank at or above n! gives one item: element 0, tuser (range error)
// high, tlast high.
// Flow: the front classifies an item in the accepting cycle and queues it
// (two entries). The back loads it, then per digit produces one quotient
// bit per cycle of the restoring division by k! (4 bits for k>=8, 3 for
// k>=4, 2 for k>=2, 1 for k=1, none for k=0), then takes one pick step.
// An error item goes straight from the load to the pick step. The back
// takes no new rank from the queue until it has finished the last one.
// When the receiver stalls, the output register holds its item and the back
// waits in its pick step; the queue keeps taking input until it is full.
// Reset clears the queue, the sequencer and the output valid at once.
module permutation_unrank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,     // perm_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [28:0] perm_index, [31:29] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [3:0] element, [7:4] zero
  output logic        m_axis_tlast,    // last
  output logic        m_axis_tuser     // range_error
);
  import punrank_pkg::*;

  logic             push_valid, push_ready;
  cmd_t             push_cmd;
  logic             pop_valid, pop_ready;
  cmd_t             pop_cmd;
  logic [ElemW-1:0] elem;

  // classify: clamp n, check the rank against n!
  punrank_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_index_i   (s_axis_tdata[IdxW-1:0]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // decouple front and back
  punrank_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // digit extraction and element pick
  punrank_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_elem_o  (elem),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {(8 - ElemW)'(0), elem};

endmodule

FILE: design/punrank_checker.sv
`include "permutation_unrank_assert.svh"

module punrank_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  logic       out_stall;
  logic       err_item;
  logic [9:0] out_word;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign err_item  = m_axis_tvalid && m_axis_tuser;
  assign out_word  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

  // a stalled item holds
  `PU_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled item changed")

  // a range error is a single item with element zero
  `PU_ASSERT(a_err_form, err_item |-> m_axis_tlast && m_axis_tdata == 8'd0, "bad error item")

  // elements stay inside 0 .. 11
  `PU_ASSERT(a_elem_range, m_axis_tvalid |-> (m_axis_tdata < 8'd12), "element out of range")

  // nothing comes out during reset
  `PU_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind permutation_unrank punrank_checker u_punrank_checker (.*);
